// ----- rtl/core/cdh_pkg.sv -----
// Shared types, constants and the point-logging function of the climb detector.
// No dependencies; every other file of the block imports this package.
package cdh_pkg;

   // Configuration register indexes.
   localparam logic CSR_HYSTERESIS = 1'b0;
   localparam logic CSR_MIN_ASCENT = 1'b1;

   localparam logic [9:0]  HYST_RESET       = 10'd30;
   localparam logic [9:0]  HYST_DEFAULT_DM  = 10'd30;
   localparam logic [15:0] MIN_ASCENT_RESET = 16'd1000;

   // Ceiling of 2^22 / 10; exact truncated division for magnitudes up to 2^17.
   localparam int          DIV10_SHIFT = 22;
   localparam logic [18:0] DIV10_RECIP = 19'd419431;

   localparam logic signed [15:0] ASCENT_MAX = 16'sd16383;
   localparam logic [15:0]        COUNT_MAX  = 16'hFFFF;

   // One input word after the first register, with the altitude already in meters.
   typedef struct packed {
      logic signed [17:0] altitude_dm;
      logic [31:0]        sample_time;
      logic               first_sample;
      logic signed [14:0] altitude_m;
   } item_type;

   typedef struct packed {
      logic signed [14:0] running_alt;
      logic [1:0]         points_seen;
      logic signed [14:0] older_alt;
      logic signed [14:0] middle_alt;
      logic [31:0]        middle_time;
      logic               ext_valid;
      logic signed [14:0] ext_alt;
      logic [31:0]        ext_time;
      logic [15:0]        climb_count;
   } track_state_type;

   typedef struct packed {
      logic [31:0] climb_start_time;
      logic [31:0] climb_stop_time;
      logic [13:0] ascent_m;
      logic [15:0] climb_number;
   } climb_result_type;

   typedef struct packed {
      track_state_type  st;
      logic             found;
      climb_result_type res;
   } log_out_type;

   // Ten times a running altitude, widened to compare against decimeters.
   function automatic logic signed [19:0] times_ten(logic signed [14:0] r);
      logic signed [19:0] x;
      x = {{5{r[14]}}, r};
      return (x <<< 3) + (x <<< 1);
   endfunction

   // Pushes one point into the three-point window and tests the middle one.
   function automatic log_out_type log_point(track_state_type st,
                                             logic signed [14:0] alt,
                                             logic [31:0] t,
                                             logic [15:0] min_ascent);
      log_out_type        o;
      logic               peak;
      logic               trough;
      logic signed [15:0] rise;
      logic signed [19:0] rise10;
      o       = '0;
      o.st    = st;
      peak    = (st.middle_alt > st.older_alt) && (st.middle_alt > alt);
      trough  = (st.middle_alt < st.older_alt) && (st.middle_alt < alt);
      rise    = {st.middle_alt[14], st.middle_alt} - {st.ext_alt[14], st.ext_alt};
      rise10  = ({{4{rise[15]}}, rise} <<< 3) + ({{4{rise[15]}}, rise} <<< 1);
      if (st.points_seen >= 2'd2) begin
         if (peak || trough) begin
            if (st.ext_valid && (rise10 >= $signed({4'b0000, min_ascent}))) begin
               if (st.climb_count != COUNT_MAX) begin
                  o.st.climb_count = st.climb_count + 16'd1;
               end
               o.found                = 1'b1;
               o.res.climb_start_time = st.ext_time;
               o.res.climb_stop_time  = st.middle_time;
               o.res.ascent_m         = (rise > ASCENT_MAX) ? ASCENT_MAX[13:0] : rise[13:0];
               o.res.climb_number     = o.st.climb_count;
            end
            o.st.ext_valid = 1'b1;
            o.st.ext_alt   = st.middle_alt;
            o.st.ext_time  = st.middle_time;
         end
      end else begin
         o.st.points_seen = st.points_seen + 2'd1;
      end
      o.st.older_alt   = st.middle_alt;
      o.st.middle_alt  = alt;
      o.st.middle_time = t;
      return o;
   endfunction

endpackage

// ----- rtl/core/cdh_input_stage.sv -----
// Input register of the climb detector: captures a word and converts decimeters
// to meters (truncated toward zero) by a reciprocal multiply. Uses cdh_pkg.
module cdh_input_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic signed [17:0] altitude_dm,
   input  logic [31:0]        sample_time,
   input  logic               first_sample,
   input  logic               advance,
   output logic               item_valid,
   output cdh_pkg::item_type  item
);
   import cdh_pkg::*;

   logic               valid_ff, valid_in;
   item_type           item_ff, item_in;
   logic [17:0]        mag;
   logic [36:0]        prod;
   logic [14:0]        quot_mag;
   logic signed [14:0] quot;

   assign in_ready = !valid_ff || advance;

   always_comb begin
      mag      = altitude_dm[17] ? (~altitude_dm + 18'd1) : altitude_dm;
      prod     = 37'(mag) * 37'(DIV10_RECIP);
      quot_mag = prod[DIV10_SHIFT +: 15];
      quot     = altitude_dm[17] ? -$signed(quot_mag) : $signed(quot_mag);
   end

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
      if (in_valid && in_ready) begin
         item_in.altitude_dm  = altitude_dm;
         item_in.sample_time  = sample_time;
         item_in.first_sample = first_sample;
         item_in.altitude_m   = quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
endmodule

// ----- rtl/core/cdh_climb_tracker.sv -----
// Hysteresis tracking, extremum window and climb test, with the configuration
// registers and the result register. Uses cdh_pkg.
module cdh_climb_tracker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [15:0]               csr_wdata,
   input  logic                      item_valid,
   input  cdh_pkg::item_type         item,
   output logic                      advance,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output cdh_pkg::climb_result_type rsp_res
);
   import cdh_pkg::*;

   logic [9:0]         hyst_ff, hyst_in;
   logic [15:0]        min_ascent_ff, min_ascent_in;
   track_state_type    state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   climb_result_type   rsp_res_ff, rsp_res_in;

   logic signed [19:0] alt20, h20;
   track_state_type    st0, st0m, st1, st1m;
   log_out_type        up_log, down_log;
   logic               up_hit, down_hit, found;
   climb_result_type   res;

   always_comb begin
      hyst_in       = hyst_ff;
      min_ascent_in = min_ascent_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_HYSTERESIS: hyst_in       = csr_wdata[9:0];
            CSR_MIN_ASCENT: min_ascent_in = csr_wdata;
         endcase
      end
   end

   assign advance = !rsp_valid_ff || rsp_ready;

   always_comb begin
      alt20 = {{2{item.altitude_dm[17]}}, item.altitude_dm};
      h20   = {10'd0, (hyst_ff <= 10'd1) ? HYST_DEFAULT_DM : hyst_ff};

      // A first sample clears everything and seeds the running altitude.
      st0 = state_ff;
      if (item.first_sample) begin
         st0             = '0;
         st0.running_alt = item.altitude_m;
      end

      // The upward test runs first; the downward test sees its moved altitude.
      up_hit           = alt20 > (times_ten(st0.running_alt) + h20);
      st0m             = st0;
      st0m.running_alt = item.altitude_m;
      up_log = log_point(st0m, item.altitude_m, item.sample_time, min_ascent_ff);
      st1    = up_hit ? up_log.st : st0;

      down_hit         = alt20 < (times_ten(st1.running_alt) - h20);
      st1m             = st1;
      st1m.running_alt = item.altitude_m;
      down_log = log_point(st1m, item.altitude_m, item.sample_time, min_ascent_ff);

      found = (up_hit && up_log.found) || (down_hit && down_log.found);
      res   = (up_hit && up_log.found) ? up_log.res : down_log.res;

      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (advance) begin
         rsp_valid_in = item_valid && found;
         if (item_valid) begin
            state_in = down_hit ? down_log.st : st1;
            if (found) begin
               rsp_res_in = res;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hyst_ff       <= HYST_RESET;
         min_ascent_ff <= MIN_ASCENT_RESET;
         state_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hyst_ff       <= hyst_in;
         min_ascent_ff <= min_ascent_in;
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_res   = rsp_res_ff;
endmodule

// ----- rtl/core/climb_detector_hysteresis_core.sv -----
// Top level of the climb detector with hysteresis: stream ports, word packing
// and checks. Depends on cdh_pkg, cdh_input_stage and cdh_climb_tracker.
//
//   channel   direction  handshake               payload
//   req_      in         req_tvalid/req_tready   altitude, time tag; tuser = first flag
//   rsp_      out        rsp_tvalid/rsp_tready   start/stop time, ascent, climb number
//   csr_      in         csr_we (no wait)        csr_index selects register, csr_wdata
//
// One word is accepted every cycle while no result is stalled. A word is
// captured in the input register, its altitude divided by ten with a
// reciprocal multiply on the way in, and its result (if any) is held in the
// result register. The state update loop in the tracker sets the rate. Reset
// is synchronous and restores the register defaults (hysteresis 30 dm,
// minimum ascent 1000 dm) and clears all tracking state. A stalled result
// holds the tracker; the input register still takes one word.
module climb_detector_hysteresis_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [17:0] altitude_dm (signed), [49:18] sample_time, [55:50] zero
   input  logic [55:0] req_tdata,
   // [0] first_sample
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] climb_start_time, [63:32] climb_stop_time, [77:64] ascent_m,
   // [93:78] climb_number, [95:94] zero
   output logic [95:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import cdh_pkg::*;

   logic             advance;
   logic             item_valid;
   item_type         item;
   climb_result_type rsp_res;

   // The input register also computes the altitude in meters.
   cdh_input_stage u_input (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .altitude_dm  ($signed(req_tdata[17:0])),
      .sample_time  (req_tdata[49:18]),
      .first_sample (req_tuser),
      .advance      (advance),
      .item_valid   (item_valid),
      .item         (item)
   );

   // The tracker owns the configuration, the detection state and the result.
   cdh_climb_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item       (item),
      .advance    (advance),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_res    (rsp_res)
   );

   assign rsp_tdata = {2'b00, rsp_res.climb_number, rsp_res.ascent_m,
                       rsp_res.climb_stop_time, rsp_res.climb_start_time};

   // The input side may only stall when a result is waiting and not taken.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without a blocked result");

   // Climb numbers start at one, so a shown result never carries zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_res.climb_number != 16'd0))
      else $error("result with climb number zero");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");
endmodule

// ----- tb/sv/climb_detector_hysteresis_core_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for climb_detector_hysteresis_core: stream stimulus, an
// in-bench climb predictor and a result checker. Depends on cdh_pkg and the RTL.

module climb_detector_hysteresis_core_test;
   import cdh_pkg::*;

   // Time for a word to pass the input and result registers, plus some margin,
   // before a register write may follow the last expected word.
   localparam int SETTLE_CYCLES = 4;
   localparam int MAX_REPORTS   = 10;
   localparam int ALT_MIN_DM    = -131072;
   localparam int ALT_MAX_DM    = 131071;
   localparam int PHASE_WORDS   = 170;
   localparam int ZIGZAG_WORDS  = 100;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [17:0] altitude_dm (signed), [49:18] sample_time, [55:50] zero
   logic [55:0] req_tdata  = '0;
   // [0] first_sample
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [31:0] climb_start_time, [63:32] climb_stop_time, [77:64] ascent_m,
   // [93:78] climb_number, [95:94] zero
   logic [95:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic        csr_index  = CSR_HYSTERESIS;
   logic [15:0] csr_wdata  = '0;

   climb_detector_hysteresis_core DUT (.*);

   always #6 clock = ~clock;

   // Predictor copy of the configuration and the tracking state.
   logic [9:0]         hyst_dm;
   logic [15:0]        min_ascent_dm;
   logic signed [14:0] run_alt_m;
   logic [1:0]         point_count;
   logic signed [14:0] older_m;
   logic signed [14:0] middle_m;
   logic [31:0]        middle_time;
   logic               ext_valid;
   logic signed [14:0] ext_m;
   logic [31:0]        ext_time;
   logic [15:0]        climb_total;

   // Climbs predicted but not yet seen on the result channel, oldest first.
   climb_result_type pending_climbs[$];

   int          mismatches    = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   logic [31:0] time_tag      = '0;

   function automatic int rand_between(int lo, int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic int clamp_alt(int a);
      if (a < ALT_MIN_DM) return ALT_MIN_DM;
      if (a > ALT_MAX_DM) return ALT_MAX_DM;
      return a;
   endfunction

   function automatic void clear_track();
      run_alt_m   = '0;
      point_count = '0;
      older_m     = '0;
      middle_m    = '0;
      middle_time = '0;
      ext_valid   = 1'b0;
      ext_m       = '0;
      ext_time    = '0;
      climb_total = '0;
   endfunction

   // Pushes a point into the three-point window. When the middle point is a
   // strict peak or trough it becomes the new extremum, and a rise over the
   // previous extremum of at least the minimum ascent is a climb.
   function automatic bit log_track_point(logic signed [14:0] alt, logic [31:0] t,
                                          output climb_result_type climb);
      int rise;
      bit found;
      found = 1'b0;
      climb = '0;
      if (point_count >= 2'd2) begin
         if ((middle_m > older_m && middle_m > alt) ||
             (middle_m < older_m && middle_m < alt)) begin
            rise = int'(middle_m) - int'(ext_m);
            if (ext_valid && rise * 10 >= int'(min_ascent_dm)) begin
               if (climb_total != COUNT_MAX) climb_total = climb_total + 16'd1;
               climb.climb_start_time = ext_time;
               climb.climb_stop_time  = middle_time;
               climb.ascent_m         = (rise > 16383) ? 14'h3FFF : rise[13:0];
               climb.climb_number     = climb_total;
               found = 1'b1;
            end
            ext_valid = 1'b1;
            ext_m     = middle_m;
            ext_time  = middle_time;
         end
      end else begin
         point_count = point_count + 2'd1;
      end
      older_m     = middle_m;
      middle_m    = alt;
      middle_time = t;
      return found;
   endfunction

   // Predicts the effect of one accepted sample word.
   function automatic void track_sample(logic signed [17:0] alt_dm, logic [31:0] t,
                                        logic first);
      int               a;
      int               band;
      bit               found;
      climb_result_type climb;
      climb_result_type spare;
      a     = alt_dm;
      band  = (hyst_dm <= 10'd1) ? 30 : int'(hyst_dm);
      found = 1'b0;
      if (first) begin
         clear_track();
         run_alt_m = 15'(a / 10);
      end
      // The upward test runs first; the downward test sees the moved altitude
      // and may log a second, equal point in the same step.
      if (a > int'(run_alt_m) * 10 + band) begin
         run_alt_m = 15'(a / 10);
         found = log_track_point(run_alt_m, t, climb);
      end
      if (a < int'(run_alt_m) * 10 - band) begin
         run_alt_m = 15'(a / 10);
         if (found) void'(log_track_point(run_alt_m, t, spare));
         else found = log_track_point(run_alt_m, t, climb);
      end
      if (found) pending_climbs.push_back(climb);
   endfunction

   // Sends one sample word with the current time tag, after random idle
   // cycles, and predicts it once it is accepted. The valid stays high on
   // return so that back-to-back words need no gap.
   task automatic send_sample(input int alt_dm, input logic first);
      logic signed [17:0] alt;
      alt = 18'(alt_dm);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, time_tag, alt};
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      track_sample(alt, time_tag, first);
      time_tag = time_tag + $urandom_range(1, 4);
   endtask

   // Holds off the sender until every predicted climb has come out, then lets
   // the pipeline empty of words that cause no result.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (pending_climbs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One write, with the enable low again before the task returns.
   task automatic write_register(input logic index, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == CSR_HYSTERESIS) hyst_dm = value[9:0];
      else min_ascent_dm = value;
      @(posedge clock);
   endtask

   // Right after reset, with no first-sample flag, the running altitude starts
   // at zero and the default registers apply.
   task automatic test_start_without_first();
      send_sample(1500, 1'b0);
      send_sample(200, 1'b0);
      send_sample(2500, 1'b0);
      send_sample(100, 1'b0);
      wait_for_results();
   endtask

   // Altitude at both ends of its range, time tags at zero and all ones. The
   // rise of these climbs is far over the ascent field's ceiling.
   task automatic test_field_extremes();
      write_register(CSR_MIN_ASCENT, 16'hFFFF);
      time_tag = '0;
      send_sample(ALT_MIN_DM, 1'b1);
      time_tag = '1;
      send_sample(ALT_MAX_DM, 1'b0);
      send_sample(ALT_MIN_DM, 1'b0);
      send_sample(ALT_MAX_DM, 1'b0);
      send_sample(ALT_MIN_DM, 1'b0);
      wait_for_results();
   endtask

   // With a band of 2 dm a negative sample can cross upward and then, since
   // the division truncates toward zero, downward in the same step. The upper
   // bits of the hysteresis write are not part of the register.
   task automatic test_double_crossing();
      write_register(CSR_HYSTERESIS, 16'hFC02);
      write_register(CSR_MIN_ASCENT, 16'd0);
      send_sample(-50, 1'b1);
      send_sample(-15, 1'b0);
      send_sample(-300, 1'b0);
      send_sample(-15, 1'b0);
      send_sample(90, 1'b0);
      send_sample(-15, 1'b0);
      wait_for_results();
   endtask

   // Hysteresis codes 0 and 1 act as 30 dm; a falling pair of extrema gives
   // no climb even with a zero minimum ascent.
   task automatic test_small_band_codes();
      write_register(CSR_HYSTERESIS, 16'd0);
      send_sample(0, 1'b1);
      send_sample(25, 1'b0);
      send_sample(35, 1'b0);
      send_sample(-5, 1'b0);
      send_sample(35, 1'b0);
      send_sample(-5, 1'b0);
      wait_for_results();
      write_register(CSR_HYSTERESIS, 16'd1);
      send_sample(31, 1'b0);
      send_sample(-5, 1'b0);
      wait_for_results();
   endtask

   // Random rides: mostly walks toward random targets, some of them near the
   // band and some near the minimum ascent, with new rides now and then and a
   // share of fully random words.
   task automatic test_random_rides();
      int hyst_set[6]   = '{30, 1023, 5, 1, 150, 2};
      int ascent_set[6] = '{1000, 50000, 100, 3000, 300, 0};
      int cur;
      int target;
      int span;
      int band;
      int steps;
      int roll;
      int sent;
      for (int p = 0; p < 6; p++) begin
         // Two phases per idle mode: sender busy, then receiver busy, then none.
         case (p / 2)
            0: begin
               send_idle_pct = 30;
               recv_idle_pct = 86;
            end
            1: begin
               send_idle_pct = 86;
               recv_idle_pct = 30;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         write_register(CSR_HYSTERESIS, 16'(hyst_set[p]));
         write_register(CSR_MIN_ASCENT, 16'(ascent_set[p]));
         band = (hyst_set[p] <= 1) ? 30 : hyst_set[p];
         cur  = rand_between(-5000, 90000);
         send_sample(cur, 1'b1);
         sent = 1;
         while (sent < PHASE_WORDS) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
               time_tag = $urandom;
               send_sample(rand_between(ALT_MIN_DM, ALT_MAX_DM), $urandom_range(0, 3) == 0);
               sent++;
            end else if (roll < 12) begin
               cur = rand_between(-5000, 90000);
               send_sample(cur, 1'b1);
               sent++;
            end else begin
               if ($urandom_range(0, 2) == 0) span = rand_between(0, 3 * band);
               else span = rand_between(0, 2 * ascent_set[p] + 4 * band);
               target = clamp_alt($urandom_range(0, 1) ? cur + span : cur - span);
               steps  = rand_between(1, 5);
               for (int k = steps; k > 0; k--) begin
                  cur = clamp_alt(cur + (target - cur) / k + rand_between(-band, band));
                  send_sample(cur, 1'b0);
                  sent++;
               end
            end
         end
         wait_for_results();
      end
   endtask

   // A zigzag with every rising pair a climb, sent back to back with an
   // always-ready receiver, so the climb number counts up by one per climb.
   task automatic test_zigzag_count();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_register(CSR_HYSTERESIS, 16'd2);
      write_register(CSR_MIN_ASCENT, 16'd0);
      send_sample(0, 1'b1);
      for (int i = 0; i < ZIGZAG_WORDS; i++) begin
         send_sample((i % 2 == 0) ? 1000 : 0, 1'b0);
      end
      wait_for_results();
   endtask

   // Result checker and receiver: each accepted result word is compared with
   // the oldest predicted climb; the ready is redrawn every cycle.
   always @(posedge clock) begin
      climb_result_type got;
      climb_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.climb_start_time = rsp_tdata[31:0];
         got.climb_stop_time  = rsp_tdata[63:32];
         got.ascent_m         = rsp_tdata[77:64];
         got.climb_number     = rsp_tdata[93:78];
         if (pending_climbs.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("unexpected climb word: start %h stop %h ascent %0d number %0d",
                        got.climb_start_time, got.climb_stop_time, got.ascent_m,
                        got.climb_number);
            end
         end else begin
            want = pending_climbs.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("climb mismatch: expected start %h stop %h ascent %0d number %0d",
                           want.climb_start_time, want.climb_stop_time, want.ascent_m,
                           want.climb_number);
                  $display("                got      start %h stop %h ascent %0d number %0d",
                           got.climb_start_time, got.climb_stop_time, got.ascent_m,
                           got.climb_number);
               end
            end
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   initial begin
      hyst_dm       = HYST_RESET;
      min_ascent_dm = MIN_ASCENT_RESET;
      clear_track();
      send_idle_pct = 30;
      recv_idle_pct = 86;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_start_without_first();
      test_field_extremes();
      test_double_crossing();
      test_small_band_codes();
      test_random_rides();
      test_zigzag_count();
      wait_for_results();
      if (mismatches == 0 && pending_climbs.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // About 1150 words; even with a result for every word and the receiver
   // idle most cycles a correct run stays under 0.2 ms, so this bound is ten
   // times that.
   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- climb_detector_hysteresis_core.f -----
rtl/core/cdh_pkg.sv
rtl/core/cdh_input_stage.sv
rtl/core/cdh_climb_tracker.sv
rtl/core/climb_detector_hysteresis_core.sv
tb/sv/climb_detector_hysteresis_core_test.sv
